// ===== src/pn_guidance_command_core_macros.svh =====
// Assertion helpers for the guidance core checker.
`ifndef PN_GUIDANCE_COMMAND_CORE_MACROS_SVH
`define PN_GUIDANCE_COMMAND_CORE_MACROS_SVH

// same-cycle implication
`define PNGC_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PNGC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pngc_pkg.sv =====
package pngc_pkg;

	localparam int DATA_W     = 32;
	localparam int NAV_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_NAV_RATIO   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUGMENTED   = 2'd2;

	localparam logic [NAV_W-1:0]      NAV_RESET = 8'd24;
	localparam logic [CFG_DATA_W-1:0] LIM_RESET = 31'd57702;

	// stage map
	localparam int QB        = 31;	// quotient bits below int32 saturation
	localparam int T2B       = 48;	// quotient bits of the target accel term
	localparam int ST_SUM    = 2;
	localparam int ST_MAG    = 3;
	localparam int SQ_FIRST  = 4;
	localparam int SQ_STEPS  = 32;
	localparam int SQ_LAST   = SQ_FIRST + SQ_STEPS - 1;
	localparam int LOS_CHK   = SQ_FIRST;
	localparam int LOS_FIRST = LOS_CHK + 1;
	localparam int LOS_LAST  = LOS_FIRST + QB - 1;
	localparam int ST_ROOT   = SQ_LAST + 1;
	localparam int VC_FIRST  = ST_ROOT + 1;
	localparam int VC_LAST   = VC_FIRST + QB - 1;
	localparam int T2_FIRST  = ST_ROOT + 1;
	localparam int T2_LAST   = T2_FIRST + T2B - 1;
	localparam int ST_VC     = VC_LAST + 1;
	localparam int ST_T1P    = ST_VC + 1;
	localparam int ST_T1     = ST_T1P + 1;
	localparam int ST_TOT    = T2_LAST + 1;
	localparam int ST_CLAMP  = ST_TOT + 1;
	localparam int ST_XMUL   = ST_CLAMP + 1;
	localparam int XY_FIRST  = ST_XMUL + 1;
	localparam int XY_LAST   = XY_FIRST + QB - 1;
	localparam int NS        = XY_LAST + 1;

	localparam logic [1:0] SKID_DEPTH = 2'd2;

	typedef struct packed {
		logic               rz;
		logic [31:0]        pxm;
		logic [31:0]        pym;
		logic               pxn;
		logic               pyn;
		logic [63:0]        pxx;
		logic [63:0]        pyy;
		logic signed [63:0] pd1;
		logic signed [63:0] pd2;
		logic signed [63:0] pc1;
		logic signed [63:0] pc2;
		logic signed [63:0] pa1;
		logic signed [63:0] pa2;
		logic [63:0]        r2;
		logic signed [64:0] dot;
		logic signed [64:0] crs;
		logic signed [64:0] c2;
		logic               dot_neg;
		logic [63:0]        dot_rem;
		logic               crs_neg;
		logic [83:0]        crs_rem;
		logic               c2_neg;
		logic [67:0]        c2_rem;
		logic [63:0]        sq_v;
		logic [63:0]        sq_res;
		logic [31:0]        r;
		logic               vc_ovf;
		logic               los_ovf;
		logic               t2_ovf;
		logic [30:0]        vc_q;
		logic [30:0]        los_q;
		logic [47:0]        t2_q;
		logic signed [31:0] vc;
		logic signed [31:0] los;
		logic               t1_neg;
		logic [63:0]        t1p;
		logic [48:0]        t1;
		logic               tot_neg;
		logic [49:0]        tot;
		logic               sat;
		logic signed [31:0] xnc;
		logic               xn_neg;
		logic [30:0]        xn_mag;
		logic               cx_neg;
		logic               cy_neg;
		logic [62:0]        cx_rem;
		logic [62:0]        cy_rem;
		logic [30:0]        cx_q;
		logic [30:0]        cy_q;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
	} pipe_t;

	typedef struct packed {
		logic signed [31:0] accel_cmd;
		logic signed [31:0] cmd_x;
		logic signed [31:0] cmd_y;
		logic signed [31:0] closing_speed;
		logic signed [31:0] los_rate;
		logic               saturated;
		logic               receding;
		logic               range_zero;
	} out_t;

endpackage

// ===== src/pn_guidance_command_core.sv =====
// Proportional navigation guidance core (pure or augmented PN). Takes one
// transaction per clock while in_ready is high. The depth is set by the
// square root of the squared range (one root bit per stage), alongside
// which the sight-line rate quotient divides by the squared range itself,
// followed by the restoring quotient units for closing speed, the target
// acceleration term and the two command components, each retiring one
// quotient bit per stage. A two-entry output buffer lets the pipe keep
// accepting while a result waits; in_ready drops only when that buffer is
// full. Configuration is taken at any time but must be written while idle.
module pn_guidance_command_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pngc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pngc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_pos_x,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_pos_y,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_vel_x,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_vel_y,
	input  logic signed [pngc_pkg::DATA_W-1:0]    tgt_acc_x,
	input  logic signed [pngc_pkg::DATA_W-1:0]    tgt_acc_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pngc_pkg::DATA_W-1:0]    accel_cmd,
	output logic signed [pngc_pkg::DATA_W-1:0]    cmd_x,
	output logic signed [pngc_pkg::DATA_W-1:0]    cmd_y,
	output logic signed [pngc_pkg::DATA_W-1:0]    closing_speed,
	output logic signed [pngc_pkg::DATA_W-1:0]    los_rate,
	output logic                                  saturated,
	output logic                                  receding,
	output logic                                  range_zero
);

	logic [pngc_pkg::NAV_W-1:0]      nav_q;
	logic [pngc_pkg::CFG_DATA_W-1:0] lim_q;
	logic                            aug_q;

	pngc_pkg::pipe_t pipe_s [1:pngc_pkg::NS];
	logic            vld_s  [1:pngc_pkg::NS];

	logic            en;
	logic [1:0]      cnt_q;
	pngc_pkg::out_t  buf0_q, buf1_q, nxt_out;
	logic            push, pop;

	function automatic logic signed [31:0] sat_s32(input logic neg, input logic ovf,
			input logic [30:0] q);
		logic [31:0] m;
		m = {1'b0, q};
		if (neg)
			sat_s32 = ovf ? {1'b1, 31'b0} : 32'd0 - m;
		else
			sat_s32 = ovf ? {1'b0, {31{1'b1}}} : m;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nav_q <= pngc_pkg::NAV_RESET;
			lim_q <= pngc_pkg::LIM_RESET;
			aug_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pngc_pkg::CFG_NAV_RATIO:   nav_q <= cfg_data[pngc_pkg::NAV_W-1:0];
				pngc_pkg::CFG_ACCEL_LIMIT: lim_q <= cfg_data;
				pngc_pkg::CFG_AUGMENTED:   aug_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = (cnt_q != pngc_pkg::SKID_DEPTH);
	assign in_ready = en;

	for (genvar s = 1; s <= pngc_pkg::NS; s++) begin : g_stg
		localparam int SQ_K  = (s >= pngc_pkg::SQ_FIRST && s <= pngc_pkg::SQ_LAST) ?
			s - pngc_pkg::SQ_FIRST : 0;
		localparam int LOS_I = (s >= pngc_pkg::LOS_FIRST && s <= pngc_pkg::LOS_LAST) ?
			pngc_pkg::QB - 1 - (s - pngc_pkg::LOS_FIRST) : 0;
		localparam int VC_I  = (s >= pngc_pkg::VC_FIRST && s <= pngc_pkg::VC_LAST) ?
			pngc_pkg::QB - 1 - (s - pngc_pkg::VC_FIRST) : 0;
		localparam int T2_I  = (s >= pngc_pkg::T2_FIRST && s <= pngc_pkg::T2_LAST) ?
			pngc_pkg::T2B - 1 - (s - pngc_pkg::T2_FIRST) : 0;
		localparam int XY_I  = (s >= pngc_pkg::XY_FIRST && s <= pngc_pkg::XY_LAST) ?
			pngc_pkg::QB - 1 - (s - pngc_pkg::XY_FIRST) : 0;

		pngc_pkg::pipe_t d;

		if (s == 1) begin : g_in
			always_comb begin
				d = '0;
				d.rz  = (rel_pos_x == '0) && (rel_pos_y == '0);
				d.pxn = rel_pos_x[31];
				d.pyn = rel_pos_y[31];
				d.pxm = rel_pos_x[31] ? 32'(-rel_pos_x) : 32'(rel_pos_x);
				d.pym = rel_pos_y[31] ? 32'(-rel_pos_y) : 32'(rel_pos_y);
				d.pxx = 64'(d.pxm) * 64'(d.pxm);
				d.pyy = 64'(d.pym) * 64'(d.pym);
				d.pd1 = 64'(rel_pos_x) * 64'(rel_vel_x);
				d.pd2 = 64'(rel_pos_y) * 64'(rel_vel_y);
				d.pc1 = 64'(rel_pos_x) * 64'(rel_vel_y);
				d.pc2 = 64'(rel_pos_y) * 64'(rel_vel_x);
				d.pa1 = 64'(rel_pos_x) * 64'(tgt_acc_y);
				d.pa2 = 64'(rel_pos_y) * 64'(tgt_acc_x);
			end
		end else begin : g_work
			always_comb begin
				pngc_pkg::pipe_t p;
				logic [64:0]  t65;
				logic [63:0]  bit64, t64, n64, d64;
				logic [94:0]  n95, d95;
				logic [80:0]  n81, d81;
				logic [71:0]  m72;
				logic [49:0]  a50, b50;
				logic [31:0]  vm, lm;
				logic [30:0]  mag31;
				p = pipe_s[s-1];
				d = p;
				t65 = '0; bit64 = '0; t64 = '0; n64 = '0; d64 = '0;
				n95 = '0; d95 = '0; n81 = '0; d81 = '0; m72 = '0;
				a50 = '0; b50 = '0; vm = '0; lm = '0; mag31 = '0;

				if (s == pngc_pkg::ST_SUM) begin
					d.r2  = p.pxx + p.pyy;
					d.dot = {p.pd1[63], p.pd1} + {p.pd2[63], p.pd2};
					d.crs = {p.pc1[63], p.pc1} - {p.pc2[63], p.pc2};
					d.c2  = {p.pa1[63], p.pa1} - {p.pa2[63], p.pa2};
				end

				if (s == pngc_pkg::ST_MAG) begin
					d.dot_neg = p.dot[64];
					t65 = 65'd0 - p.dot;
					d.dot_rem = p.dot[64] ? t65[63:0] : p.dot[63:0];
					d.crs_neg = p.crs[64];
					t65 = 65'd0 - p.crs;
					d.crs_rem = {(p.crs[64] ? t65[63:0] : p.crs[63:0]), 20'b0};
					d.c2_neg = p.c2[64];
					t65 = 65'd0 - p.c2;
					d.c2_rem = {4'b0, (p.c2[64] ? t65[63:0] : p.c2[63:0])};
					d.sq_v   = p.r2;
					d.sq_res = '0;
				end

				if (s >= pngc_pkg::SQ_FIRST && s <= pngc_pkg::SQ_LAST) begin
					bit64 = 64'd1 << (62 - 2 * SQ_K);
					t64 = p.sq_res + bit64;
					if (p.sq_v >= t64) begin
						d.sq_v   = p.sq_v - t64;
						d.sq_res = (p.sq_res >> 1) + bit64;
					end else begin
						d.sq_res = p.sq_res >> 1;
					end
				end

				if (s == pngc_pkg::LOS_CHK) begin
					d.los_ovf = {11'b0, p.crs_rem} >= {p.r2, 31'b0};
					m72 = p.c2_rem[63:0] * nav_q;
					d.c2_rem = m72[71:4];
				end

				if (s >= pngc_pkg::LOS_FIRST && s <= pngc_pkg::LOS_LAST) begin
					n95 = {11'b0, p.crs_rem};
					d95 = {31'b0, p.r2} << LOS_I;
					if (n95 >= d95) begin
						t64 = '0;
						n95 = n95 - d95;
						d.crs_rem = n95[83:0];
						d.los_q[LOS_I] = 1'b1;
					end
				end

				if (s == pngc_pkg::ST_ROOT) begin
					d.r = p.sq_res[31:0];
					d.vc_ovf = {1'b0, p.dot_rem} >= {2'b0, p.sq_res[31:0], 31'b0};
					d.t2_ovf = {12'b0, p.c2_rem} >= {p.sq_res[31:0], 48'b0};
					d.los = sat_s32(p.crs_neg, p.los_ovf, p.los_q);
				end

				if (s >= pngc_pkg::VC_FIRST && s <= pngc_pkg::VC_LAST) begin
					n64 = p.dot_rem;
					d64 = {32'b0, p.r} << VC_I;
					if (n64 >= d64) begin
						d.dot_rem = n64 - d64;
						d.vc_q[VC_I] = 1'b1;
					end
				end

				if (s >= pngc_pkg::T2_FIRST && s <= pngc_pkg::T2_LAST) begin
					n81 = {13'b0, p.c2_rem};
					d81 = {49'b0, p.r} << T2_I;
					if (n81 >= d81) begin
						n81 = n81 - d81;
						d.c2_rem = n81[67:0];
						d.t2_q[T2_I] = 1'b1;
					end
				end

				if (s == pngc_pkg::ST_VC)
					d.vc = sat_s32(!p.dot_neg, p.vc_ovf, p.vc_q);

				if (s == pngc_pkg::ST_T1P) begin
					vm = p.vc[31] ? 32'd0 - p.vc : p.vc;
					lm = p.los[31] ? 32'd0 - p.los : p.los;
					d.t1p = 64'(vm) * 64'(lm);
					d.t1_neg = p.vc[31] != p.los[31];
				end

				if (s == pngc_pkg::ST_T1) begin
					m72 = p.t1p * nav_q;
					d.t1 = m72[71:23];
				end

				if (s == pngc_pkg::ST_TOT) begin
					a50 = {1'b0, p.t1};
					b50 = p.t2_ovf ? (50'd1 << pngc_pkg::T2B) : {2'b0, p.t2_q};
					if (!aug_q) begin
						d.tot_neg = p.t1_neg;
						d.tot = a50;
					end else if (p.t1_neg == p.c2_neg) begin
						d.tot_neg = p.t1_neg;
						d.tot = a50 + b50;
					end else if (a50 >= b50) begin
						d.tot_neg = p.t1_neg;
						d.tot = a50 - b50;
					end else begin
						d.tot_neg = p.c2_neg;
						d.tot = b50 - a50;
					end
				end

				if (s == pngc_pkg::ST_CLAMP) begin
					d.sat = p.tot > {19'b0, lim_q};
					mag31 = d.sat ? lim_q : p.tot[30:0];
					d.xn_mag = mag31;
					d.xn_neg = p.tot_neg;
					d.xnc = p.tot_neg ? 32'd0 - {1'b0, mag31} : {1'b0, mag31};
				end

				if (s == pngc_pkg::ST_XMUL) begin
					d.cx_rem = 63'(p.xn_mag) * 63'(p.pym);
					d.cy_rem = 63'(p.xn_mag) * 63'(p.pxm);
					d.cx_neg = p.xn_neg == p.pyn;
					d.cy_neg = p.xn_neg != p.pxn;
				end

				if (s >= pngc_pkg::XY_FIRST && s <= pngc_pkg::XY_LAST) begin
					d64 = {32'b0, p.r} << XY_I;
					n64 = {1'b0, p.cx_rem};
					if (n64 >= d64) begin
						t64 = n64 - d64;
						d.cx_rem = t64[62:0];
						d.cx_q[XY_I] = 1'b1;
					end
					n64 = {1'b0, p.cy_rem};
					if (n64 >= d64) begin
						t64 = n64 - d64;
						d.cy_rem = t64[62:0];
						d.cy_q[XY_I] = 1'b1;
					end
				end

				if (s == pngc_pkg::NS) begin
					d.cx = p.cx_neg ? 32'd0 - {1'b0, p.cx_q} : {1'b0, p.cx_q};
					d.cy = p.cy_neg ? 32'd0 - {1'b0, p.cy_q} : {1'b0, p.cy_q};
					if (p.rz) begin
						d.xnc = '0;
						d.cx  = '0;
						d.cy  = '0;
						d.vc  = '0;
						d.los = '0;
						d.sat = 1'b0;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[s] <= 1'b0;
			else if (en)
				vld_s[s] <= (s == 1) ? in_valid : vld_s[(s == 1) ? 1 : s-1];
		end

		always_ff @(posedge clk) begin
			if (en)
				pipe_s[s] <= d;
		end
	end

	always_comb begin
		nxt_out.accel_cmd     = pipe_s[pngc_pkg::NS].xnc;
		nxt_out.cmd_x         = pipe_s[pngc_pkg::NS].cx;
		nxt_out.cmd_y         = pipe_s[pngc_pkg::NS].cy;
		nxt_out.closing_speed = pipe_s[pngc_pkg::NS].vc;
		nxt_out.los_rate      = pipe_s[pngc_pkg::NS].los;
		nxt_out.saturated     = pipe_s[pngc_pkg::NS].sat;
		nxt_out.receding      = pipe_s[pngc_pkg::NS].vc[31];
		nxt_out.range_zero    = pipe_s[pngc_pkg::NS].rz;
	end

	assign push = en && vld_s[pngc_pkg::NS];
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1)
				buf0_q <= nxt_out;
			else
				buf0_q <= buf1_q;
		end else if (push) begin
			if (cnt_q == 2'd0)
				buf0_q <= nxt_out;
			else
				buf1_q <= nxt_out;
		end
	end

	assign out_valid     = (cnt_q != 2'd0);
	assign accel_cmd     = buf0_q.accel_cmd;
	assign cmd_x         = buf0_q.cmd_x;
	assign cmd_y         = buf0_q.cmd_y;
	assign closing_speed = buf0_q.closing_speed;
	assign los_rate      = buf0_q.los_rate;
	assign saturated     = buf0_q.saturated;
	assign receding      = buf0_q.receding;
	assign range_zero    = buf0_q.range_zero;

endmodule

// ===== src/pngc_checker.sv =====
`include "pn_guidance_command_core_macros.svh"

module pngc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pngc_pkg::DATA_W-1:0]  accel_cmd,
	input logic signed [pngc_pkg::DATA_W-1:0]  cmd_x,
	input logic signed [pngc_pkg::DATA_W-1:0]  cmd_y,
	input logic signed [pngc_pkg::DATA_W-1:0]  closing_speed,
	input logic signed [pngc_pkg::DATA_W-1:0]  los_rate,
	input logic                                saturated,
	input logic                                receding,
	input logic                                range_zero
);

	logic        zero_out;
	logic        no_cmd;
	logic [162:0] out_bus;

	assign zero_out = (accel_cmd == '0) && (cmd_x == '0) && (cmd_y == '0) &&
		(closing_speed == '0) && (los_rate == '0) && !saturated && !receding;
	assign no_cmd  = (cmd_x == '0) && (cmd_y == '0);
	assign out_bus = {accel_cmd, cmd_x, cmd_y, closing_speed, los_rate,
		saturated, receding, range_zero};

	`PNGC_ASSERT_NOW(a_rz_zero, clk, arst_n, out_valid && range_zero, zero_out, "range zero leak")
	`PNGC_ASSERT_NOW(a_recede, clk, arst_n, out_valid, receding == closing_speed[31], "receding flag")
	`PNGC_ASSERT_NOW(a_cmd_split, clk, arst_n, out_valid && accel_cmd == '0, no_cmd, "cmd split")
	`PNGC_ASSERT_NOW(a_ready, clk, arst_n, !in_ready, out_valid, "stall without output")
	`PNGC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_bus), "hold")

endmodule

bind pn_guidance_command_core pngc_checker u_pngc_checker (.*);

// ===== test/pn_guidance_command_checker.sv =====
`timescale 1ns / 1ps

module pn_guidance_command_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pngc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pngc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_pos_x,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_pos_y,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_vel_x,
	input  logic signed [pngc_pkg::DATA_W-1:0]    rel_vel_y,
	input  logic signed [pngc_pkg::DATA_W-1:0]    tgt_acc_x,
	input  logic signed [pngc_pkg::DATA_W-1:0]    tgt_acc_y,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [pngc_pkg::DATA_W-1:0]    accel_cmd,
	input  logic signed [pngc_pkg::DATA_W-1:0]    cmd_x,
	input  logic signed [pngc_pkg::DATA_W-1:0]    cmd_y,
	input  logic signed [pngc_pkg::DATA_W-1:0]    closing_speed,
	input  logic signed [pngc_pkg::DATA_W-1:0]    los_rate,
	input  logic                                  saturated,
	input  logic                                  receding,
	input  logic                                  range_zero,
	output int                                    errors,
	output int                                    pending,
	output int                                    checked
);

	typedef logic signed [127:0] wide_t;
	localparam wide_t I32_MAX  = 128'sh7fffffff;
	localparam wide_t I32_MIN  = -128'sh80000000;
	localparam wide_t TERM_MAX = 128'sh4000000000000000;

	logic [pngc_pkg::NAV_W-1:0]      nav_q;
	logic [pngc_pkg::CFG_DATA_W-1:0] lim_q;
	logic                            aug_q;
	pngc_pkg::out_t                  cmd_expected[$];

	function automatic logic [63:0] range_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bm;
		res = '0;
		bm = 64'h4000000000000000;
		while (bm > v)
			bm = bm >> 2;
		while (bm != 0) begin
			if (v >= res + bm) begin
				v = v - (res + bm);
				res = (res >> 1) + bm;
			end else begin
				res = res >> 1;
			end
			bm = bm >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [31:0] clip32(input wide_t v);
		if (v > I32_MAX)
			return 32'sh7fffffff;
		if (v < I32_MIN)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic wide_t mag(input wide_t v);
		return v < 0 ? -v : v;
	endfunction

	function automatic wide_t cap_term(input wide_t v);
		return v > TERM_MAX ? TERM_MAX : v;
	endfunction

	function automatic pngc_pkg::out_t predict_guidance(
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [31:0] pvx, input logic signed [31:0] pvy,
		input logic signed [31:0] pax, input logic signed [31:0] pay);
		wide_t x, y, vx, vy, ax, ay, r2, r, q, t1, t2, tot, tmag, navw, limw, xn;
		logic signed [31:0] vc, los;
		pngc_pkg::out_t o;
		x = px; y = py; vx = pvx; vy = pvy; ax = pax; ay = pay;
		o = '0;
		r2 = x * x + y * y;
		if (r2 == 0) begin
			o.range_zero = 1'b1;
			return o;
		end
		r = $signed({64'd0, range_sqrt(r2[63:0])});
		navw = $signed({120'd0, nav_q});
		limw = $signed({97'd0, lim_q});

		q = -(x * vx + y * vy) / r;
		vc = clip32(q);
		q = ((x * vy - y * vx) <<< 20) / r2;
		los = clip32(q);

		t1 = cap_term((mag(wide_t'(vc)) * mag(wide_t'(los)) * navw) / (128'sd1 <<< 23));
		if ((vc < 0) != (los < 0))
			t1 = -t1;
		tot = t1;
		if (aug_q) begin
			q = x * ay - y * ax;
			t2 = cap_term((mag(q) * navw) / (r * 16));
			tot = tot + (q < 0 ? -t2 : t2);
		end
		tmag = mag(tot);
		if (tmag > limw) begin
			tmag = limw;
			o.saturated = 1'b1;
		end
		xn = tot < 0 ? -tmag : tmag;

		o.accel_cmd = xn[31:0];
		q = -(xn * y) / r;
		o.cmd_x = q[31:0];
		q = (xn * x) / r;
		o.cmd_y = q[31:0];
		o.closing_speed = vc;
		o.los_rate = los;
		o.receding = vc < 0;
		return o;
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		checked = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nav_q <= pngc_pkg::NAV_RESET;
			lim_q <= pngc_pkg::LIM_RESET;
			aug_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
			pngc_pkg::CFG_NAV_RATIO: begin
				nav_q <= cfg_data[pngc_pkg::NAV_W-1:0];
			end
			pngc_pkg::CFG_ACCEL_LIMIT: begin
				lim_q <= cfg_data;
			end
			pngc_pkg::CFG_AUGMENTED: begin
				aug_q <= cfg_data[0];
			end
			default: begin
			end
			endcase
		end
	end

	always @(posedge clk) begin
		pngc_pkg::out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (cmd_expected.size() == 0) begin
					report_mismatch("unexpected transaction", accel_cmd, '0);
				end else begin
					want = cmd_expected.pop_front();
					checked++;
					if (accel_cmd !== want.accel_cmd)
						report_mismatch("accel_cmd", accel_cmd, want.accel_cmd);
					if (cmd_x !== want.cmd_x)
						report_mismatch("cmd_x", cmd_x, want.cmd_x);
					if (cmd_y !== want.cmd_y)
						report_mismatch("cmd_y", cmd_y, want.cmd_y);
					if (closing_speed !== want.closing_speed)
						report_mismatch("closing_speed", closing_speed, want.closing_speed);
					if (los_rate !== want.los_rate)
						report_mismatch("los_rate", los_rate, want.los_rate);
					if (saturated !== want.saturated)
						report_mismatch("saturated", saturated, want.saturated);
					if (receding !== want.receding)
						report_mismatch("receding", receding, want.receding);
					if (range_zero !== want.range_zero)
						report_mismatch("range_zero", range_zero, want.range_zero);
				end
			end
			if (in_valid && in_ready)
				cmd_expected.push_back(predict_guidance(rel_pos_x, rel_pos_y, rel_vel_x,
					rel_vel_y, tgt_acc_x, tgt_acc_y));
		end
		pending <= cmd_expected.size();
	end

endmodule

// ===== test/tb_pn_guidance_command_core.sv =====
`timescale 1ns / 1ps

module tb_pn_guidance_command_core;

	localparam int DRAIN_CYCLES = 140;
	localparam logic [pngc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pngc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pngc_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic signed [31:0]    rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y, tgt_acc_x, tgt_acc_y;
	logic                  out_valid;
	logic                  out_ready;
	logic signed [31:0]    accel_cmd, cmd_x, cmd_y, closing_speed, los_rate;
	logic                  saturated, receding, range_zero;
	int                    errors, pending, checked;
	bit                    quiet;
	int                    sent;

	pn_guidance_command_core DUT (.*);

	pn_guidance_command_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [pngc_pkg::CFG_IDX_W-1:0] idx,
		input logic [pngc_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// drive one transaction; returns at the edge that accepts it
	task automatic send_measurement(input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [31:0] vx, input logic signed [31:0] vy,
		input logic signed [31:0] ax, input logic signed [31:0] ay);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rel_pos_x <= px; rel_pos_y <= py;
		rel_vel_x <= vx; rel_vel_y <= vy;
		tgt_acc_x <= ax; tgt_acc_y <= ay;
		forever begin
			@(negedge clk);
			if (in_ready) begin
				@(posedge clk);
				break;
			end
		end
		sent++;
	endtask

	function automatic logic signed [31:0] pick_value(input int span);
		case (span)
		0: return $urandom;
		1: return $signed($urandom_range(0, 8191)) - 4096;
		2: return $signed($urandom_range(0, 2097151)) - 1048576;
		3: begin
			case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return 1;
			4: return -1;
			default: return 32'sh80000001;
			endcase
		end
		default: return $signed($urandom_range(0, 33554431)) - 16777216;
		endcase
	endfunction

	task automatic directed_set;
		localparam logic signed [31:0] MX = 32'sh7fffffff;
		localparam logic signed [31:0] MN = 32'sh80000000;
		send_measurement(0, 0, 5000, -300, 77, 12);
		send_measurement(0, 0, MX, MN, MX, MN);
		send_measurement(MX, MX, MX, MX, MX, MX);
		send_measurement(MN, MN, MN, MN, MN, MN);
		send_measurement(MX, MN, MN, MX, MN, MX);
		send_measurement(1, 0, 0, MX, 0, MX);
		send_measurement(0, -1, MN, 0, MX, 0);
		send_measurement(1, 1, MN, MX, MX, MN);
		send_measurement(2560000, 512000, -256000, 25600, 0, -8243);
		send_measurement(2560000, 512000, 256000, -25600, 8243, 0);
		send_measurement(-1280000, 0, 0, 12800, 0, 0);
		send_measurement(256, 256, -256, 256, -1, 1);
		send_measurement(32'sh55555555, 32'shaaaaaaaa, 32'sh33333333, 32'shcccccccc,
			32'sh0f0f0f0f, 32'shf0f0f0f0);
	endtask

	task automatic random_set(input int count);
		int span, k;
		logic signed [31:0] f[6];
		for (int n = 0; n < count; n++) begin
			span = $urandom_range(0, 9);
			// half plausible engagement geometry, the rest anything goes
			if (span < 5) begin
				f[0] = pick_value(4); f[1] = pick_value(4);
				f[2] = pick_value(2); f[3] = pick_value(2);
				f[4] = pick_value(1); f[5] = pick_value(1);
			end else begin
				for (k = 0; k < 6; k++)
					f[k] = pick_value($urandom_range(0, 3));
			end
			send_measurement(f[0], f[1], f[2], f[3], f[4], f[5]);
		end
	endtask

	task automatic run_phase(input logic [7:0] nav, input logic [30:0] lim, input logic aug,
		input int count);
		settle();
		write_reg(pngc_pkg::CFG_NAV_RATIO, {23'd0, nav});
		write_reg(pngc_pkg::CFG_ACCEL_LIMIT, lim);
		write_reg(pngc_pkg::CFG_AUGMENTED, {30'd0, aug});
		directed_set();
		random_set(count);
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		rel_pos_x = '0; rel_pos_y = '0;
		rel_vel_x = '0; rel_vel_y = '0;
		tgt_acc_x = '0; tgt_acc_y = '0;
		quiet = 1'b0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults before any write
		directed_set();
		random_set(80);
		in_valid <= 1'b0;
		settle();
		write_reg(CFG_SPARE, 31'h7fffffff);
		run_phase(8'd24, 31'd57702, 1'b0, 230);
		run_phase(8'd255, 31'h7fffffff, 1'b1, 230);
		run_phase(8'd0, 31'd0, 1'b1, 200);
		run_phase(8'd1, 31'd1, 1'b0, 200);
		run_phase(8'd40, 31'd1000000, 1'b1, 230);
		run_phase(8'($urandom_range(0, 255)), 31'($urandom_range(0, 32'h7fffffff)), 1'b1, 150);
		quiet = 1'b1;
		run_phase(8'($urandom_range(0, 255)), 31'($urandom_range(0, 2000000)), 1'b0, 150);

		settle();
		$display("Sent %0d transactions over 8 register settings, %0d results checked",
			sent, checked);
		$display("Covered zero range, field extremes, saturation and both guidance modes");
		if (errors == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== pn_guidance_command_core.f =====
+incdir+src
src/pngc_pkg.sv
src/pn_guidance_command_core.sv
src/pngc_checker.sv
test/pn_guidance_command_checker.sv
test/tb_pn_guidance_command_core.sv
